### sv/assert_macros.svh
// Assertion macros shared by the filter RTL.
// Needs signals clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FNAF_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FNAF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fnaf_pkg.sv
// Shared types and constants of the four-neighbor average filter.
// No dependencies; used by the channel interfaces and the top level.
package fnaf_pkg;

  localparam int MAX_COLS       = 2048;
  localparam int CHANNEL_BITS   = 8;
  localparam int COL_BITS       = $clog2(MAX_COLS);
  localparam int ROW_BITS       = 16;
  localparam int COLS_CFG_BITS  = 12;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam int SUM_BITS       = CHANNEL_BITS + 2;

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_ROWS = 1'b0,
    REG_FRAME_COLS = 1'b1
  } cfg_index_t;

  localparam logic [ROW_BITS-1:0]      FRAME_ROWS_RESET = 16'd1920;
  localparam logic [COLS_CFG_BITS-1:0] FRAME_COLS_RESET = 12'd1080;

  // Floor of the mean of four channel values
  function automatic chan_t avg4(chan_t a, chan_t b, chan_t c, chan_t d);
    logic [SUM_BITS-1:0] sum;
    sum = SUM_BITS'(a) + SUM_BITS'(b) + SUM_BITS'(c) + SUM_BITS'(d);
    return sum[SUM_BITS-1:2];
  endfunction

endpackage

### sv/fnaf_ifs.sv
// Valid/ready channel interfaces for pixels in and averaged results out.
// Depends on fnaf_pkg for the channel width.
interface fnaf_pix_if import fnaf_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red_in;
  chan_t green_in;
  chan_t blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface fnaf_res_if import fnaf_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red_out;
  chan_t green_out;
  chan_t blue_out;
  logic  frame_last;

  modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

### sv/four_neighbor_average_filter.sv
// Top level of the four-neighbor average filter over a raster RGB stream.
// Depends on fnaf_pkg, fnaf_ifs.sv and assert_macros.svh.
//
// Usage:
//   pix_in  : one RGB pixel per transfer, raster order, row by row.
//   res_out : one averaged pixel per interior center; frame_last marks the
//             final interior center of the frame. Border pixels give nothing.
//   cfg_*   : write frame_rows (index 0) and frame_cols (index 1) while idle.
// The result for the center at row r-1, column c comes out after the pixel
// at row r, column c has been taken, so output lags input by one row.
// A result for the pixel that completes its neighborhood passes through the
// line store read at the transfer edge, then the result register.
// Throughput: one pixel per clock while the receiver does not stall, set by
// the single write port of each line store and the registered read ahead of it.
// Reset clears the row/column counters and the window and loads the default
// frame size (1920 rows, 1080 columns); line stores are not cleared and hold
// garbage until the first rows of a frame are written.
// When the receiver stalls, the result register holds and the pipeline stage
// behind it absorbs one more pixel; pix_in.ready drops once that pixel has a
// result to deliver.
`include "assert_macros.svh"

module four_neighbor_average_filter import fnaf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  fnaf_pix_if.sink                  pix_in,
  fnaf_res_if.source                res_out,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // Stage-1 record for an accepted pixel
  typedef struct packed {
    pixel_t              down;
    logic [COL_BITS-1:0] col;
    logic                emit;
    logic                last;
    logic                row_end;
  } s1_t;

  logic [ROW_BITS-1:0]      frame_rows;
  logic [COLS_CFG_BITS-1:0] frame_cols;
  logic [COLS_CFG_BITS-1:0] eff_cols;
  logic [ROW_BITS-1:0]      eff_rows;

  logic [COL_BITS-1:0]      col_count;
  logic [ROW_BITS-1:0]      row_count;
  logic [COLS_CFG_BITS-1:0] col_plus1;
  logic [COLS_CFG_BITS-1:0] col_plus2;
  logic [ROW_BITS:0]        row_plus1;
  logic [COL_BITS-1:0]      col_right;
  logic                     row_end;
  logic                     frame_end;
  logic                     emit;
  logic                     last;

  pixel_t                   older_store  [MAX_COLS];
  pixel_t                   recent_store [MAX_COLS];
  pixel_t                   up_rd;
  pixel_t                   mid_rd;
  pixel_t                   right_rd;
  pixel_t                   centre_pixel;

  s1_t                      s1;
  logic                     s1_valid;
  logic                     s1_advance;
  logic                     store_write;
  logic                     bypass_mid;
  logic                     bypass_right;

  logic                     in_ready;
  logic                     in_xfer;
  logic                     out_valid;
  logic                     out_enable;
  pixel_t                   avg_pix;
  pixel_t                   out_pix;
  logic                     out_last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= FRAME_ROWS_RESET;
      frame_cols <= FRAME_COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_ROWS: frame_rows <= cfg_data[ROW_BITS-1:0];
        REG_FRAME_COLS: frame_cols <= cfg_data[COLS_CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size: zero counts as one, columns saturate at store depth
  always_comb begin
    if (frame_cols == '0) begin
      eff_cols = COLS_CFG_BITS'(1);
    end else if (frame_cols > COLS_CFG_BITS'(MAX_COLS)) begin
      eff_cols = COLS_CFG_BITS'(MAX_COLS);
    end else begin
      eff_cols = frame_cols;
    end
    eff_rows = (frame_rows == '0) ? ROW_BITS'(1) : frame_rows;
  end

  // Position decode for the pixel at the input
  always_comb begin
    col_plus1 = COLS_CFG_BITS'(col_count) + COLS_CFG_BITS'(1);
    col_plus2 = COLS_CFG_BITS'(col_count) + COLS_CFG_BITS'(2);
    row_plus1 = (ROW_BITS+1)'(row_count) + (ROW_BITS+1)'(1);
    col_right = col_count + COL_BITS'(1);
    row_end   = col_plus1 >= eff_cols;
    frame_end = row_end && (row_plus1 >= (ROW_BITS+1)'(eff_rows));
    emit      = (row_count >= ROW_BITS'(2)) && (col_count != '0) &&
                (col_plus2 <= eff_cols) && (row_count < eff_rows);
    last      = (row_plus1 == (ROW_BITS+1)'(eff_rows)) && (col_plus2 == eff_cols);
  end

  // Handshake: output register, then stage 1, then input
  assign out_enable   = !out_valid || res_out.ready;
  assign s1_advance   = !s1.emit || out_enable;
  assign in_ready     = !s1_valid || s1_advance;
  assign in_xfer      = pix_in.valid && in_ready;
  assign pix_in.ready = in_ready;

  // Advance column and row counters on each pixel transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_xfer) begin
      if (row_end) begin
        col_count <= '0;
        row_count <= frame_end ? '0 : row_plus1[ROW_BITS-1:0];
      end else begin
        col_count <= col_plus1[COL_BITS-1:0];
      end
    end
  end

  // Line store update happens once, as stage 1 drains
  assign store_write  = s1_valid && s1_advance;
  assign bypass_mid   = store_write && (s1.col == col_count);
  assign bypass_right = store_write && (s1.col == col_right);

  always_ff @(posedge clk) begin
    if (store_write) begin
      older_store[s1.col]  <= mid_rd;
      recent_store[s1.col] <= s1.down;
    end
  end

  // Read the line stores for the incoming pixel; forward a same-cycle write
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      up_rd    <= bypass_mid   ? mid_rd  : older_store[col_count];
      mid_rd   <= bypass_mid   ? s1.down : recent_store[col_count];
      right_rd <= bypass_right ? s1.down : recent_store[col_right];
    end
  end

  // Stage 1 holds the pixel while its store data is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1.down.red   <= pix_in.red_in;
      s1.down.green <= pix_in.green_in;
      s1.down.blue  <= pix_in.blue_in;
      s1.col        <= col_count;
      s1.emit       <= emit;
      s1.last       <= last;
      s1.row_end    <= row_end;
    end
  end

  // Slide the window over the previous row; drop it at row end
  always_ff @(posedge clk) begin
    if (rst) begin
      centre_pixel <= '0;
    end else if (store_write) begin
      centre_pixel <= s1.row_end ? '0 : mid_rd;
    end
  end

  // Average of up, down, left and right per channel
  always_comb begin
    avg_pix.red   = avg4(up_rd.red,   s1.down.red,   centre_pixel.red,   right_rd.red);
    avg_pix.green = avg4(up_rd.green, s1.down.green, centre_pixel.green, right_rd.green);
    avg_pix.blue  = avg4(up_rd.blue,  s1.down.blue,  centre_pixel.blue,  right_rd.blue);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_enable) begin
      out_valid <= s1_valid && s1.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_enable && s1_valid && s1.emit) begin
      out_pix  <= avg_pix;
      out_last <= s1.last;
    end
  end

  assign res_out.valid      = out_valid;
  assign res_out.red_out    = out_pix.red;
  assign res_out.green_out  = out_pix.green;
  assign res_out.blue_out   = out_pix.blue;
  assign res_out.frame_last = out_last;

  // Checks on the pipeline and counters
  `FNAF_ASSERT_IMPL(a_stall_blocks_input, s1_valid && s1.emit && out_valid && !res_out.ready, !pix_in.ready, "input taken while a result is blocked")
  `FNAF_ASSERT_NEXT(a_result_loads, s1_valid && s1.emit && s1_advance, out_valid, "stage 1 result lost")
  `FNAF_ASSERT_NEXT(a_frame_wrap, in_xfer && frame_end, row_count == '0 && col_count == '0, "counters did not wrap at frame end")

endmodule
